/* src/nss_pkg.sv */
`default_nettype none

package nss_pkg;

   localparam int MAP_ROWS = 12;

   localparam logic [26:0] WORD_SYNC  = 27'h0000000;
   localparam logic [26:0] WORD_BLACK = 27'h2020202;
   localparam logic [26:0] WORD_WHITE = 27'h6060606;

   localparam logic [1:0] LVL_SYNC  = 2'd0;
   localparam logic [1:0] LVL_BLANK = 2'd1;
   localparam logic [1:0] LVL_VIDEO = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADV,
      S_LOOK,
      S_FETCH,
      S_EMIT
   } seq_state_type;

   typedef struct packed {
      logic [5:0] steps;
      logic [1:0] level;
   } seg_entry_type;

   typedef struct packed {
      logic        valid;
      logic [26:0] word;
      logic [1:0]  level;
      logic        last;
   } beat_type;

   function automatic logic [2:0] map_table(input logic [3:0] row);
      logic [2:0] t;
      begin
         unique case (row)
            4'd0:    t = 3'd0;
            4'd1:    t = 3'd1;
            4'd2:    t = 3'd0;
            4'd3:    t = 3'd2;
            4'd4:    t = 3'd3;
            4'd5:    t = 3'd0;
            4'd6:    t = 3'd4;
            4'd7:    t = 3'd1;
            4'd8:    t = 3'd5;
            4'd9:    t = 3'd0;
            4'd10:   t = 3'd2;
            4'd11:   t = 3'd3;
            default: t = 3'd0;
         endcase
         return t;
      end
   endfunction

   function automatic logic [7:0] map_repeat(input logic [3:0] row);
      logic [7:0] r;
      begin
         unique case (row)
            4'd0:    r = 8'd3;
            4'd1:    r = 8'd3;
            4'd2:    r = 8'd3;
            4'd3:    r = 8'd18;
            4'd4:    r = 8'd235;
            4'd5:    r = 8'd3;
            4'd6:    r = 8'd1;
            4'd7:    r = 8'd2;
            4'd8:    r = 8'd1;
            4'd9:    r = 8'd2;
            4'd10:   r = 8'd17;
            4'd11:   r = 8'd234;
            default: r = 8'd0;
         endcase
         return r;
      end
   endfunction

   function automatic logic [26:0] pixel_word(input logic [1:0] lvl,
                                              input logic [5:0] seg_rem,
                                              input logic [7:0] row_rem,
                                              input logic [7:0] frame);
      logic [7:0]  a;
      logic [7:0]  b;
      logic [26:0] w;
      begin
         a = frame - {2'b00, seg_rem};
         b = frame - {3'b000, row_rem[7:3]};
         if (lvl == LVL_SYNC) begin
            w = WORD_SYNC;
         end else if (lvl == LVL_BLANK) begin
            w = WORD_BLACK;
         end else if ((a & b) != 8'd0) begin
            w = WORD_WHITE;
         end else begin
            w = WORD_BLACK;
         end
         return w;
      end
   endfunction

endpackage

`default_nettype wire

/* src/nss_seg_rom.sv */
`default_nettype none

module nss_seg_rom #(
   parameter int ACTIVE_WIDTH = 40
) (
   input  wire logic                  clock,
   input  wire logic [5:0]            rd_addr,
   output nss_pkg::seg_entry_type     rd_data
);
   import nss_pkg::*;

   localparam logic [5:0] ACT  = 6'(ACTIVE_WIDTH);
   localparam logic [5:0] TAIL = 6'(47 - ACTIVE_WIDTH);

   seg_entry_type rd_data_ff;

   function automatic seg_entry_type seg_entry(input logic [5:0] addr);
      seg_entry_type e;
      begin
         case (addr)
            6'o00: e = '{6'd4,  LVL_SYNC};
            6'o01: e = '{6'd26, LVL_BLANK};
            6'o02: e = '{6'd4,  LVL_SYNC};
            6'o03: e = '{6'd26, LVL_BLANK};
            6'o10: e = '{6'd26, LVL_SYNC};
            6'o11: e = '{6'd4,  LVL_BLANK};
            6'o12: e = '{6'd26, LVL_SYNC};
            6'o13: e = '{6'd4,  LVL_BLANK};
            6'o20: e = '{6'd4,  LVL_SYNC};
            6'o21: e = '{6'd19, LVL_BLANK};
            6'o22: e = '{6'd18, LVL_BLANK};
            6'o23: e = '{6'd19, LVL_BLANK};
            6'o30: e = '{6'd4,  LVL_SYNC};
            6'o31: e = '{6'd9,  LVL_BLANK};
            6'o32: e = '{ACT,   LVL_VIDEO};
            6'o33: e = '{TAIL,  LVL_BLANK};
            6'o40: e = '{6'd4,  LVL_SYNC};
            6'o41: e = '{6'd26, LVL_BLANK};
            6'o42: e = '{6'd26, LVL_SYNC};
            6'o43: e = '{6'd4,  LVL_BLANK};
            6'o50: e = '{6'd25, LVL_SYNC};
            6'o51: e = '{6'd5,  LVL_BLANK};
            6'o52: e = '{6'd3,  LVL_SYNC};
            6'o53: e = '{6'd27, LVL_BLANK};
            default: e = '{6'd0, LVL_SYNC};
         endcase
         return e;
      end
   endfunction

   always_ff @(posedge clock) begin
      rd_data_ff <= seg_entry(rd_addr);
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/nss_seq.sv */
`default_nettype none

module nss_seq #(
   parameter int ACTIVE_WIDTH = 40,
   parameter int MAX_BURST    = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [5:0]  req_burst_len,
   output logic             req_stall,
   input  wire logic        out_ready,
   output nss_pkg::beat_type beat
);
   import nss_pkg::*;

   localparam int CW = $clog2(MAX_BURST + 1);

   seq_state_type state_ff, state_in;
   logic [3:0]    map_row_ff, map_row_in;
   logic [7:0]    row_rem_ff, row_rem_in;
   logic [2:0]    seg_idx_ff, seg_idx_in;
   logic [5:0]    seg_rem_ff, seg_rem_in;
   logic [1:0]    seg_lvl_ff, seg_lvl_in;
   logic [7:0]    frame_ff, frame_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    guard_ff, guard_in;

   logic [CW-1:0] burst_n;
   logic [5:0]    rom_addr;
   seg_entry_type rom_q;

   assign burst_n  = (req_burst_len > MAX_BURST) ? CW'(MAX_BURST) : CW'(req_burst_len);
   assign rom_addr = {map_table(map_row_ff), seg_idx_ff};

   nss_seg_rom #(
      .ACTIVE_WIDTH(ACTIVE_WIDTH)
   ) u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         map_row_ff <= 4'd0;
         row_rem_ff <= 8'd1;
         seg_idx_ff <= 3'd0;
         seg_rem_ff <= 6'd1;
         seg_lvl_ff <= LVL_SYNC;
         frame_ff   <= 8'd0;
         count_ff   <= '0;
         guard_ff   <= 2'd0;
      end else begin
         state_ff   <= state_in;
         map_row_ff <= map_row_in;
         row_rem_ff <= row_rem_in;
         seg_idx_ff <= seg_idx_in;
         seg_rem_ff <= seg_rem_in;
         seg_lvl_ff <= seg_lvl_in;
         frame_ff   <= frame_in;
         count_ff   <= count_in;
         guard_ff   <= guard_in;
      end
   end

   always_comb begin
      logic [3:0] nrow;
      nrow       = map_row_ff + 4'd1;
      state_in   = state_ff;
      map_row_in = map_row_ff;
      row_rem_in = row_rem_ff;
      seg_idx_in = seg_idx_ff;
      seg_rem_in = seg_rem_ff;
      seg_lvl_in = seg_lvl_ff;
      frame_in   = frame_ff;
      count_in   = count_ff;
      guard_in   = guard_ff;
      beat       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && (burst_n != '0)) begin
               count_in = burst_n;
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            if (seg_rem_ff == 6'd0) begin
               guard_in = 2'd0;
               state_in = S_LOOK;
            end else if (out_ready) begin
               seg_rem_in = seg_rem_ff - 6'd1;
               beat.valid = 1'b1;
               beat.word  = pixel_word(seg_lvl_ff, seg_rem_in, row_rem_ff, frame_ff);
               beat.level = seg_lvl_ff;
               beat.last  = (count_ff == CW'(1));
               count_in   = count_ff - CW'(1);
               state_in   = beat.last ? S_IDLE : S_ADV;
            end
         end
         S_LOOK: begin
            seg_idx_in = seg_idx_ff + 3'd1;
            if (rom_q.steps != 6'd0) begin
               seg_rem_in = rom_q.steps;
               seg_lvl_in = rom_q.level;
               state_in   = S_EMIT;
            end else begin
               // end of table: next play of the row, or next map row
               if (row_rem_ff == 8'd0) begin
                  if (nrow >= 4'(MAP_ROWS)) begin
                     nrow     = 4'd0;
                     frame_in = frame_ff + 8'd1;
                  end
                  map_row_in = nrow;
                  row_rem_in = map_repeat(nrow);
               end else begin
                  row_rem_in = row_rem_ff - 8'd1;
               end
               seg_idx_in = 3'd0;
               guard_in   = guard_ff + 2'd1;
               state_in   = (guard_ff == 2'd3) ? S_EMIT : S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_LOOK;
         end
         S_EMIT: begin
            if (out_ready) begin
               beat.valid = 1'b1;
               beat.word  = pixel_word(seg_lvl_ff, seg_rem_ff, row_rem_ff, frame_ff);
               beat.level = seg_lvl_ff;
               beat.last  = (count_ff == CW'(1));
               count_in   = count_ff - CW'(1);
               state_in   = beat.last ? S_IDLE : S_ADV;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   a_beat_needs_room: assert property (@(posedge clock) disable iff (reset)
      beat.valid |-> out_ready)
      else $error("beat issued while output register full");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (beat.valid && beat.last) |=> (state_ff == S_IDLE))
      else $error("burst continued after last beat");

   a_look_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK) |-> ($past(state_ff) == S_ADV || $past(state_ff) == S_FETCH))
      else $error("table entry used without a read cycle");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      map_row_ff < 4'(MAP_ROWS))
      else $error("map row out of range");

   a_no_beat_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !beat.valid)
      else $error("beat issued while idle");

endmodule

`default_nettype wire

/* src/nss_out_reg.sv */
`default_nettype none

module nss_out_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire nss_pkg::beat_type beat,
   output logic                  out_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [26:0]           rsp_drive_word,
   output logic [1:0]            rsp_level,
   output logic                  rsp_last
);
   import nss_pkg::*;

   logic        valid_ff, valid_in;
   logic [26:0] word_ff;
   logic [1:0]  level_ff;
   logic        last_ff;

   assign out_ready = !valid_ff || !rsp_stall;
   assign valid_in  = beat.valid || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat.valid) begin
         word_ff  <= beat.word;
         level_ff <= beat.level;
         last_ff  <= beat.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_drive_word = word_ff;
   assign rsp_level      = level_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

/* src/ntsc_sync_sequencer.sv */
`default_nettype none

// NTSC composite sync sequencer: each request beat asks for a burst of
// req_burst_len words (0 gives nothing, above MAX_BURST is clipped) and the
// block returns one rsp beat per word, rsp_last marking the final word.
// Requests are taken only while no burst is in progress. Inside a segment a
// word is issued from the ADV state; a word that starts a new segment first
// goes through LOOK, since the segment table ROM has a registered read; a
// word that also crosses a row goes through LOOK, FETCH and LOOK again. A
// word waits while the output register is full and rsp_stall is high.

module ntsc_sync_sequencer #(
   parameter int ACTIVE_WIDTH = 40,
   parameter int MAX_BURST    = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [5:0]  req_burst_len,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [26:0]      rsp_drive_word,
   output logic [1:0]       rsp_level,
   output logic             rsp_last
);
   import nss_pkg::*;

   beat_type beat;
   logic     out_ready;

   nss_seq #(
      .ACTIVE_WIDTH (ACTIVE_WIDTH),
      .MAX_BURST    (MAX_BURST)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_burst_len (req_burst_len),
      .req_stall     (req_stall),
      .out_ready     (out_ready),
      .beat          (beat)
   );

   nss_out_reg u_out (
      .clock          (clock),
      .reset          (reset),
      .beat           (beat),
      .out_ready      (out_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_drive_word (rsp_drive_word),
      .rsp_level      (rsp_level),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

/* sim/nss_checker.sv */
module nss_checker #(
   parameter int ACTIVE_WIDTH = 40,
   parameter int MAX_BURST    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [5:0]  req_burst_len,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [26:0] rsp_drive_word,
   input  logic [1:0]  rsp_level,
   input  logic        rsp_last,
   output int          mismatches,
   output int          words_owed
);
   import nss_pkg::*;

   typedef struct packed {
      logic [26:0] word;
      logic [1:0]  level;
      logic        last;
   } sync_word_type;

   // segment table per map row, then repeat count per map row, row 0 first
   localparam logic [47:0] LINE_TABLES  = 48'h0102_3041_5023;
   localparam logic [95:0] LINE_REPEATS = 96'h030303_12eb03_010201_0211ea;

   logic [3:0] row_at;
   logic [7:0] row_left;
   logic [2:0] seg_idx;
   logic [5:0] seg_left;
   logic [1:0] seg_lvl;
   logic [7:0] frame;

   sync_word_type owed_q[$];
   sync_word_type head;
   int            fail_tally = 0;

   // {steps, level} of one entry in a segment table
   function automatic logic [7:0] segment_entry(input logic [2:0] tbl, input logic [2:0] idx);
      logic [31:0] lens;
      logic [7:0]  lvls;
      lens = '0;
      lvls = '0;
      case (tbl)
         3'd0, 3'd1, 3'd4, 3'd5: begin
            lvls = {LVL_SYNC, LVL_BLANK, LVL_SYNC, LVL_BLANK};
         end
         3'd2: begin
            lvls = {LVL_SYNC, LVL_BLANK, LVL_BLANK, LVL_BLANK};
         end
         3'd3: begin
            lvls = {LVL_SYNC, LVL_BLANK, LVL_VIDEO, LVL_BLANK};
         end
         default: begin
            lvls = '0;
         end
      endcase
      case (tbl)
         3'd0:    lens = {8'd4, 8'd26, 8'd4, 8'd26};
         3'd1:    lens = {8'd26, 8'd4, 8'd26, 8'd4};
         3'd2:    lens = {8'd4, 8'd19, 8'd18, 8'd19};
         3'd3:    lens = {8'd4, 8'd9, 8'(ACTIVE_WIDTH), 8'(47 - ACTIVE_WIDTH)};
         3'd4:    lens = {8'd4, 8'd26, 8'd26, 8'd4};
         3'd5:    lens = {8'd25, 8'd5, 8'd3, 8'd27};
         default: lens = '0;
      endcase
      if (idx > 3'd3) begin
         return 8'd0;
      end
      return {lens[8*(3-int'(idx)) +: 6], lvls[2*(3-int'(idx)) +: 2]};
   endfunction

   task automatic advance_word();
      logic [2:0] tbl;
      logic [7:0] ent;
      int         g;
      if (seg_left != 6'd0) begin
         seg_left = seg_left - 6'd1;
         return;
      end
      for (g = 0; g < 4; g++) begin
         tbl = (row_at < MAP_ROWS) ? LINE_TABLES[4*(11-int'(row_at)) +: 3] : 3'd0;
         ent = segment_entry(tbl, seg_idx);
         seg_idx = seg_idx + 3'd1;
         if (ent[7:2] != 6'd0) begin
            seg_left = ent[7:2];
            seg_lvl  = ent[1:0];
            return;
         end
         if (row_left == 8'd0) begin
            row_at = row_at + 4'd1;
            if (row_at >= MAP_ROWS) begin
               row_at = 4'd0;
               frame  = frame + 8'd1;
            end
            row_left = LINE_REPEATS[8*(11-int'(row_at)) +: 8];
         end else begin
            row_left = row_left - 8'd1;
         end
         seg_idx = 3'd0;
      end
   endtask

   task automatic predict_burst(input logic [5:0] len);
      int            n;
      int            k;
      sync_word_type w;
      logic [7:0]    a;
      logic [7:0]    b;
      n = (int'(len) > MAX_BURST) ? MAX_BURST : int'(len);
      for (k = 0; k < n; k++) begin
         advance_word();
         a = frame - {2'b00, seg_left};
         b = frame - {3'b000, row_left[7:3]};
         case (seg_lvl)
            LVL_SYNC:  w.word = WORD_SYNC;
            LVL_BLANK: w.word = WORD_BLACK;
            default:   w.word = ((a & b) != 8'd0) ? WORD_WHITE : WORD_BLACK;
         endcase
         w.level = seg_lvl;
         w.last  = (k == n - 1);
         owed_q.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         row_at   = 4'd0;
         row_left = 8'd1;
         seg_idx  = 3'd0;
         seg_left = 6'd1;
         seg_lvl  = LVL_SYNC;
         frame    = 8'd0;
         owed_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_burst(req_burst_len);
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_q.size() == 0) begin
               $error("rsp beat with no word owed: drive_word %h level %0d last %0b",
                      rsp_drive_word, rsp_level, rsp_last);
               fail_tally++;
            end else begin
               head = owed_q.pop_front();
               if (rsp_drive_word !== head.word) begin
                  $error("drive_word: expected %h, got %h", head.word, rsp_drive_word);
                  fail_tally++;
               end
               if (rsp_level !== head.level) begin
                  $error("level: expected %0d, got %0d", head.level, rsp_level);
                  fail_tally++;
               end
               if (rsp_last !== head.last) begin
                  $error("last: expected %0b, got %0b", head.last, rsp_last);
                  fail_tally++;
               end
            end
         end
      end
      mismatches <= fail_tally;
      words_owed <= owed_q.size();
   end

endmodule

/* sim/tb_top.sv */
module tb_top;

   localparam int ACTIVE_WIDTH = 40;
   localparam int MAX_BURST    = 32;
   localparam int QUIET_LIMIT  = 2000;

   // burst lengths for the opening sequence, first one leftmost
   localparam logic [127:0] OPENING_LENS = 128'h01010200_04081020_213f001f_3e152a03;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [5:0]  req_burst_len = 6'd0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [26:0] rsp_drive_word;
   logic [1:0]  rsp_level;
   logic        rsp_last;

   int mismatches;
   int words_owed;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int quiet_cycles = 0;

   ntsc_sync_sequencer #(
      .ACTIVE_WIDTH (ACTIVE_WIDTH),
      .MAX_BURST    (MAX_BURST)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_burst_len  (req_burst_len),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_drive_word (rsp_drive_word),
      .rsp_level      (rsp_level),
      .rsp_last       (rsp_last)
   );

   nss_checker #(
      .ACTIVE_WIDTH (ACTIVE_WIDTH),
      .MAX_BURST    (MAX_BURST)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_burst_len  (req_burst_len),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_drive_word (rsp_drive_word),
      .rsp_level      (rsp_level),
      .rsp_last       (rsp_last),
      .mismatches     (mismatches),
      .words_owed     (words_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL ntsc_sync_sequencer");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_burst(input logic [5:0] len);
      req_valid     <= 1'b1;
      req_burst_len <= len;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic set_phase(input int phase);
      case (phase % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 66; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 66; end
         default: begin idle_pct = 19; stall_pct = 19; end
      endcase
   endtask

   initial begin
      int i;
      int r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 16; i++) begin
         send_burst(OPENING_LENS[8*(15-i) +: 6]);
      end

      for (i = 0; i < 244; i++) begin
         set_phase(i / 61);
         r = $urandom_range(99);
         if (r < 7) begin
            send_burst(6'd0);
         end else if (r < 15) begin
            send_burst(6'($urandom_range(63, 33)));
         end else begin
            send_burst(6'($urandom_range(32, 1)));
         end
      end

      req_valid <= 1'b0;
      set_phase(0);
      @(posedge clock);
      while (words_owed != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);
      if (mismatches == 0 && words_owed == 0) begin
         $display("PASS ntsc_sync_sequencer");
      end else begin
         $display("FAIL ntsc_sync_sequencer");
      end
      $finish;
   end

endmodule

/* sim.f */
src/nss_pkg.sv
src/nss_seg_rom.sv
src/nss_seq.sv
src/nss_out_reg.sv
src/ntsc_sync_sequencer.sv
sim/nss_checker.sv
sim/tb_top.sv
